@@ hdl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/fhp_pkg.sv @@
package fhp_pkg;

  localparam logic [7:0] SepChar = 8'h3A;
  localparam logic [7:0] DigitLo = 8'h30;
  localparam logic [7:0] DigitHi = 8'h39;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_NAME    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SEP  = 2'd1;
  localparam logic [1:0] STAT_SHORT   = 2'd2;
  localparam logic [1:0] STAT_CLAMPED = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } fhp_req_t;

endpackage

@@ hdl/fragment_header_parser.sv @@
// channel | handshake            | payload
// in      | in_valid / in_ready   | in_byte, last_byte
// out     | out_valid / out_ready | kind, data_byte, total_fragments, fragment_number,
//         |                       | payload_size, status, end_of_packet
//
// one byte accepted per cycle unless results stall; a byte's result is registered
// throughput is set by the input register feeding the single parse and result stage
// bytes that cause no result (junk, digits, dropped payload) still pass the parse stage
// synchronous rst clears both stages and returns the parser to the first field
// a stalled result holds the parse stage; an empty input register takes one more byte
`include "assert_macros.svh"

module fragment_header_parser #(
  parameter int PAYLOAD_MAX = 1000,
  parameter int NAME_MAX    = 29
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  data_byte,
  output logic [31:0] total_fragments,
  output logic [31:0] fragment_number,
  output logic [9:0]  payload_size,
  output logic [1:0]  status,
  output logic        end_of_packet
);
  import fhp_pkg::*;

  fhp_req_t req;
  logic     advance;

  fhp_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .req       (req)
  );

  fhp_parse #(
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .NAME_MAX    (NAME_MAX)
  ) u_parse (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .data_byte       (data_byte),
    .total_fragments (total_fragments),
    .fragment_number (fragment_number),
    .payload_size    (payload_size),
    .status          (status),
    .end_of_packet   (end_of_packet)
  );

  `ASSERT_SAME(a_accept_room, in_valid && in_ready, !req.valid || advance,
               "request accepted with input register full")

endmodule

@@ hdl/fhp_in_stage.sv @@
`include "assert_macros.svh"

module fhp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             last_byte,
  input  logic             advance,
  output fhp_pkg::fhp_req_t req
);
  import fhp_pkg::*;

  logic       valid;
  logic       last;
  logic [7:0] data;

  assign in_ready = !valid || advance;
  assign req      = '{valid: valid, last: last, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
      last <= last_byte;
    end
  end

  `ASSERT_NEXT(a_held_request, valid && !advance, valid && $stable(data) && $stable(last),
               "stalled request changed")

endmodule

@@ hdl/fhp_parse.sv @@
`include "assert_macros.svh"

module fhp_parse #(
  parameter int PAYLOAD_MAX = 1000,
  parameter int NAME_MAX    = 29
) (
  input  logic              clk,
  input  logic              rst,
  input  fhp_pkg::fhp_req_t req,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [7:0]        data_byte,
  output logic [31:0]       total_fragments,
  output logic [31:0]       fragment_number,
  output logic [9:0]        payload_size,
  output logic [1:0]        status,
  output logic              end_of_packet
);
  import fhp_pkg::*;

  localparam logic [9:0] PayloadMax = 10'(PAYLOAD_MAX);
  localparam logic [9:0] NameMax    = 10'(NAME_MAX);

  localparam logic [2:0] FLD_TOTAL   = 3'd0;
  localparam logic [2:0] FLD_FRAGNO  = 3'd1;
  localparam logic [2:0] FLD_SIZE    = 3'd2;
  localparam logic [2:0] FLD_NAME    = 3'd3;
  localparam logic [2:0] FLD_PAYLOAD = 3'd4;
  localparam logic [2:0] FLD_DONE    = 3'd5;

  logic [2:0]  field_index, field_index_next;
  logic [31:0] number_accum, number_accum_next;
  logic        digits_done, digits_done_next;
  logic [31:0] total_reg, total_reg_next;
  logic [31:0] fragno_reg, fragno_reg_next;
  logic [9:0]  size_reg, size_reg_next;
  logic        size_clamped, size_clamped_next;
  logic [9:0]  byte_count, byte_count_next;

  logic        fire;
  logic        have;
  logic [2:0]  res_kind;
  logic [7:0]  res_data;
  logic [1:0]  res_status;
  logic [35:0] accum_x10;
  logic [9:0]  count_inc;
  logic        is_sep;
  logic        is_digit;

  assign advance = !out_valid || out_ready;
  assign fire    = req.valid && advance;

  assign accum_x10 = ({4'b0, number_accum} << 3) + ({4'b0, number_accum} << 1)
                   + {32'b0, req.data[3:0] - DigitLo[3:0]};
  assign count_inc = byte_count + 10'd1;
  assign is_sep    = (req.data == SepChar);
  assign is_digit  = req.data inside {[DigitLo:DigitHi]};

  always_comb begin
    field_index_next  = field_index;
    number_accum_next = number_accum;
    digits_done_next  = digits_done;
    total_reg_next    = total_reg;
    fragno_reg_next   = fragno_reg;
    size_reg_next     = size_reg;
    size_clamped_next = size_clamped;
    byte_count_next   = byte_count;
    have       = 1'b0;
    res_kind   = KIND_HEADER;
    res_data   = 8'd0;
    res_status = STAT_OK;
    case (field_index)
      FLD_TOTAL, FLD_FRAGNO, FLD_SIZE: begin
        if (is_sep) begin
          case (field_index)
            FLD_TOTAL:  total_reg_next  = number_accum;
            FLD_FRAGNO: fragno_reg_next = number_accum;
            default: begin
              if (number_accum > {22'b0, PayloadMax}) begin
                size_reg_next     = PayloadMax;
                size_clamped_next = 1'b1;
              end else begin
                size_reg_next = number_accum[9:0];
              end
            end
          endcase
          field_index_next  = field_index + 3'd1;
          number_accum_next = 32'd0;
          digits_done_next  = 1'b0;
          byte_count_next   = 10'd0;
        end else if (!digits_done && is_digit) begin
          number_accum_next = (accum_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : accum_x10[31:0];
        end else begin
          digits_done_next = 1'b1;
        end
        if (req.last) begin
          have       = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_NO_SEP;
        end
      end
      FLD_NAME: begin
        if (is_sep) begin
          have       = 1'b1;
          res_kind   = KIND_HEADER;
          res_status = size_clamped ? STAT_CLAMPED : STAT_OK;
          if (req.last && size_reg != 10'd0) begin
            res_status = STAT_SHORT;
          end
          byte_count_next  = 10'd0;
          field_index_next = (size_reg == 10'd0) ? FLD_DONE : FLD_PAYLOAD;
        end else if (req.last) begin
          have       = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_NO_SEP;
        end else if (byte_count < NameMax) begin
          have            = 1'b1;
          res_kind        = KIND_NAME;
          res_data        = req.data;
          byte_count_next = count_inc;
        end
      end
      FLD_PAYLOAD: begin
        if (byte_count < size_reg) begin
          have            = 1'b1;
          res_kind        = KIND_PAYLOAD;
          res_data        = req.data;
          byte_count_next = count_inc;
          if (count_inc >= size_reg) begin
            field_index_next = FLD_DONE;
          end else if (req.last) begin
            res_status = STAT_SHORT;
          end
        end else begin
          field_index_next = FLD_DONE;
        end
      end
      default: begin
      end
    endcase
    if (req.last && !have) begin
      have       = 1'b1;
      res_kind   = KIND_END;
      res_data   = 8'd0;
      res_status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index  <= FLD_TOTAL;
      number_accum <= 32'd0;
      digits_done  <= 1'b0;
      total_reg    <= 32'd0;
      fragno_reg   <= 32'd0;
      size_reg     <= 10'd0;
      size_clamped <= 1'b0;
      byte_count   <= 10'd0;
    end else if (fire) begin
      if (req.last) begin
        field_index  <= FLD_TOTAL;
        number_accum <= 32'd0;
        digits_done  <= 1'b0;
        total_reg    <= 32'd0;
        fragno_reg   <= 32'd0;
        size_reg     <= 10'd0;
        size_clamped <= 1'b0;
        byte_count   <= 10'd0;
      end else begin
        field_index  <= field_index_next;
        number_accum <= number_accum_next;
        digits_done  <= digits_done_next;
        total_reg    <= total_reg_next;
        fragno_reg   <= fragno_reg_next;
        size_reg     <= size_reg_next;
        size_clamped <= size_clamped_next;
        byte_count   <= byte_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && have;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && have) begin
      kind            <= res_kind;
      data_byte       <= res_data;
      total_fragments <= total_reg_next;
      fragment_number <= fragno_reg_next;
      payload_size    <= size_reg_next;
      status          <= res_status;
      end_of_packet   <= req.last;
    end
  end

  `ASSERT_NEXT(a_last_clears, fire && req.last,
               field_index == FLD_TOTAL && byte_count == 10'd0 && size_reg == 10'd0,
               "state not cleared after last byte")
  `ASSERT_SAME(a_size_limit, 1'b1, size_reg <= PayloadMax, "size above limit")
  `ASSERT_SAME(a_name_limit, field_index == FLD_NAME, byte_count <= NameMax,
               "name count above limit")
  `ASSERT_NEXT(a_last_reports, fire && req.last, out_valid && end_of_packet,
               "last byte gave no result")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import fhp_pkg::*;

  localparam int PayloadLimit = 1000;
  localparam int NameLimit    = 29;
  localparam int RandomBytes  = 1900;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 800000;

  typedef enum logic [2:0] {
    F_TOTAL, F_NUMBER, F_SIZE, F_NAME, F_PAYLOAD, F_DONE
  } field_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [31:0] total;
    logic [31:0] fragno;
    logic [9:0]  size;
    logic [1:0]  status;
    logic        eop;
  } frag_result_t;

  typedef logic [7:0] octet_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] total_fragments;
  logic [31:0] fragment_number;
  logic [9:0]  payload_size;
  logic [1:0]  status;
  logic        end_of_packet;

  // parser state mirrored by the predictor
  field_t      fld;
  logic [31:0] accum;
  logic        digits_done;
  logic [31:0] total_q;
  logic [31:0] fragno_q;
  logic [9:0]  size_q;
  logic        clamped;
  logic [9:0]  count;

  frag_result_t expected_results[$];
  frag_result_t req_result;
  frag_result_t got;
  logic         req_has_result;

  logic quiet = 1'b1;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   err_count = 0;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   results_checked = 0;
  int   kind_seen[5] = '{default: 0};

  fragment_header_parser #(
    .PAYLOAD_MAX(PayloadLimit),
    .NAME_MAX(NameLimit)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .data_byte(data_byte),
    .total_fragments(total_fragments),
    .fragment_number(fragment_number),
    .payload_size(payload_size),
    .status(status),
    .end_of_packet(end_of_packet)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void clear_parse();
    fld = F_TOTAL;
    accum = '0;
    digits_done = 1'b0;
    total_q = '0;
    fragno_q = '0;
    size_q = '0;
    clamped = 1'b0;
    count = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last,
                                     output logic has_result, output frag_result_t r);
    logic [63:0] grown;
    has_result = 1'b0;
    r = '0;
    case (fld)
      F_TOTAL, F_NUMBER, F_SIZE: begin
        if (b == SepChar) begin
          if (fld == F_TOTAL) begin
            total_q = accum;
          end else if (fld == F_NUMBER) begin
            fragno_q = accum;
          end else if (accum > 32'(PayloadLimit)) begin
            size_q = 10'(PayloadLimit);
            clamped = 1'b1;
          end else begin
            size_q = accum[9:0];
          end
          fld = field_t'(fld + 3'd1);
          accum = '0;
          digits_done = 1'b0;
          count = '0;
        end else if (!digits_done && b >= DigitLo && b <= DigitHi) begin
          grown = 64'(accum) * 64'd10 + 64'(b) - 64'(DigitLo);
          accum = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
        end else begin
          digits_done = 1'b1;
        end
        if (last) begin
          has_result = 1'b1;
          r.kind = KIND_ERROR;
          r.status = STAT_NO_SEP;
        end
      end
      F_NAME: begin
        if (b == SepChar) begin
          has_result = 1'b1;
          r.kind = KIND_HEADER;
          r.status = clamped ? STAT_CLAMPED : STAT_OK;
          if (last && size_q != 0) r.status = STAT_SHORT;
          count = '0;
          fld = (size_q == 0) ? F_DONE : F_PAYLOAD;
        end else if (last) begin
          has_result = 1'b1;
          r.kind = KIND_ERROR;
          r.status = STAT_NO_SEP;
        end else if (count < 10'(NameLimit)) begin
          has_result = 1'b1;
          r.kind = KIND_NAME;
          r.data = b;
          count = count + 10'd1;
        end
      end
      F_PAYLOAD: begin
        if (count < size_q) begin
          has_result = 1'b1;
          r.kind = KIND_PAYLOAD;
          r.data = b;
          count = count + 10'd1;
          if (count >= size_q) fld = F_DONE;
          else if (last) r.status = STAT_SHORT;
        end else begin
          fld = F_DONE;
        end
      end
      default: ;
    endcase
    if (last && !has_result) begin
      has_result = 1'b1;
      r.kind = KIND_END;
      r.status = STAT_OK;
    end
    if (has_result) begin
      r.total = total_q;
      r.fragno = fragno_q;
      r.size = size_q;
      r.eop = last;
    end
    if (last) clear_parse();
  endfunction

  // predict on every accepted request
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
    end else if (in_valid && in_ready) begin
      parse_byte(in_byte, last_byte, req_has_result, req_result);
      if (req_has_result) expected_results.push_back(req_result);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("kind unexpected result: expected none, got kind %0d", kind);
        err_count++;
      end else begin
        got = expected_results.pop_front();
        check_field("kind", 32'(got.kind), 32'(kind));
        check_field("data_byte", 32'(got.data), 32'(data_byte));
        check_field("total_fragments", got.total, total_fragments);
        check_field("fragment_number", got.fragno, fragment_number);
        check_field("payload_size", 32'(got.size), 32'(payload_size));
        check_field("status", 32'(got.status), 32'(status));
        check_field("end_of_packet", 32'(got.eop), 32'(end_of_packet));
        results_checked++;
        if (got.kind <= KIND_END) kind_seen[got.kind]++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() + 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input octet_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  function automatic void add_text(ref octet_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_bytes(ref octet_q_t q, input int n);
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == SepChar) ? 8'h00 : b;
  endfunction

  function automatic string num_text();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $sformatf("%0d", $urandom_range(0, 20));
    if (r < 60) return $sformatf("%0d", $urandom());
    if (r < 68) return "4294967295";
    if (r < 76) return $sformatf("%0d%0d", $urandom_range(42949, 99999), $urandom());
    if (r < 82) return "";
    if (r < 88) return $sformatf("00%0d", $urandom_range(0, 999));
    if (r < 94) return $sformatf("%0dq%0d", $urandom_range(0, 99), $urandom_range(0, 9));
    return $sformatf("-%0d", $urandom_range(0, 99));
  endfunction

  task automatic random_frame();
    octet_q_t f;
    int r;
    int sz;
    int eff;
    int plen;
    int cut;
    string stext;
    f = {};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // noise with a fair share of separators
      repeat ($urandom_range(1, 16)) begin
        f.push_back(($urandom_range(0, 3) == 0) ? SepChar : 8'($urandom_range(0, 255)));
      end
      send_frame(f);
      return;
    end
    add_text(f, {num_text(), ":", num_text(), ":"});
    r = $urandom_range(0, 99);
    if (r < 10) sz = 0;
    else if (r < 85) sz = $urandom_range(1, 24);
    else if (r < 95) sz = $urandom_range(25, 80);
    else sz = $urandom_range(1001, 5000000);
    stext = $sformatf("%0d", sz);
    if ($urandom_range(0, 9) == 0) stext = {stext, "kb7"};
    add_text(f, {stext, ":"});
    repeat ($urandom_range(0, 34)) f.push_back(name_char());
    f.push_back(SepChar);
    eff = (sz > PayloadLimit) ? PayloadLimit : sz;
    r = $urandom_range(0, 99);
    if (sz > PayloadLimit && $urandom_range(0, 29) != 0) plen = $urandom_range(0, 20);
    else if (r < 70 || eff == 0) plen = eff + ((eff == 0) ? $urandom_range(0, 3) : 0);
    else if (r < 85) plen = eff + $urandom_range(1, 4);
    else plen = $urandom_range(0, eff - 1);
    add_bytes(f, plen);
    if ($urandom_range(0, 99) < 6) begin
      cut = $urandom_range(1, f.size());
      while (f.size() > cut) void'(f.pop_back());
    end
    send_frame(f);
  endtask

  task automatic test_basic();
    octet_q_t f;
    quiet = 1'b1;
    f = {};
    add_text(f, "3:1:5:ab:");
    f = {f, 8'h00, 8'hFF, 8'h41, SepChar, 8'h80, 8'h11, 8'h22};
    send_frame(f);
  endtask

  task automatic test_number_limits();
    octet_q_t f;
    quiet = 1'b0;
    f = {};
    add_text(f, "4294967295:99999999999:1001:");
    f = {f, 8'hFF, 8'h01, SepChar};
    send_frame(f);
    f = {};
    add_text(f, "0:4294967296:1000000:x:");
    f = {f, 8'h00, 8'hFF, 8'h5A};
    send_frame(f);
  endtask

  task automatic test_special_cases();
    octet_q_t f;
    quiet = 1'b0;
    f = {};
    add_text(f, "12x3::0:nm:");
    send_frame(f);
    f = {};
    add_text(f, "1:1:0:a:zz");
    send_frame(f);
    f = {};
    add_text(f, "1:2:1:");
    repeat (NameLimit + 3) f.push_back(8'h41);
    add_text(f, ":p");
    send_frame(f);
    f = {};
    add_text(f, "x5:7:3");
    send_frame(f);
    f = {};
    add_text(f, "7:3:2:ab");
    send_frame(f);
    f = {};
    add_text(f, "5");
    send_frame(f);
    f = {};
    add_text(f, ":");
    send_frame(f);
  endtask

  task automatic test_backpressure();
    octet_q_t f;
    quiet = 1'b1;
    f = {};
    add_text(f, "2:1:30:burst:");
    add_bytes(f, 30);
    hold_asks = hold_asks + 1;
    send_frame(f);
  endtask

  task automatic test_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      quiet = ($urandom_range(0, 9) == 0);
      if (hold_asks < 2 && bytes_sent - start > RandomBytes / 2) hold_asks = hold_asks + 1;
      random_frame();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_basic();
    test_number_limits();
    test_special_cases();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    last_byte <= 1'b0;
    quiet = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("testbench: %0d bytes in %0d datagrams, %0d results checked",
             bytes_sent, frames_sent, results_checked);
    $display("testbench: header %0d, name %0d, payload %0d, error %0d, end %0d",
             kind_seen[KIND_HEADER], kind_seen[KIND_NAME], kind_seen[KIND_PAYLOAD],
             kind_seen[KIND_ERROR], kind_seen[KIND_END]);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
